>>> sv/cte_pkg.sv
package cte_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int MAX_RESULTS = 16;
    localparam int LIST_MAX    = (TABLE_SLOTS < MAX_RESULTS) ? TABLE_SLOTS : MAX_RESULTS;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    localparam int CMD_W  = 2;
    localparam int ID_W   = 8;
    localparam int EP_W   = 4 * ID_W;
    localparam int CNT_W  = 5;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture a new command
        logic exec;   // run add, remove or unused command
        logic step;   // emit one list result
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic is_list;
        logic step_last;
    } t_sts;

endpackage

>>> sv/cte_ctrl.sv
module cte_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  cte_pkg::t_sts i_sts,
    output cte_pkg::t_ctl o_ctl
);
    import cte_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_list) begin
                    o_ctl.step = 1'b1;
                    n_state    = i_sts.step_last ? S_IDLE : S_LIST;
                end else begin
                    o_ctl.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_LIST: begin
                o_ctl.step = 1'b1;
                if (i_sts.step_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

>>> sv/cte_datapath.sv
module cte_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cte_pkg::t_ctl                i_ctl,
    output cte_pkg::t_sts                o_sts,
    input  logic [cte_pkg::CMD_W-1:0]    i_cmd,
    input  logic [cte_pkg::ID_W-1:0]     i_src_module,
    input  logic [cte_pkg::ID_W-1:0]     i_src_port,
    input  logic [cte_pkg::ID_W-1:0]     i_dst_module,
    input  logic [cte_pkg::ID_W-1:0]     i_dst_port,
    input  logic [cte_pkg::CNT_W-1:0]    i_list_limit,
    output logic                         o_valid,
    output logic [cte_pkg::STAT_W-1:0]   o_status,
    output logic                         o_has_entry,
    output logic [cte_pkg::ID_W-1:0]     o_out_src_module,
    output logic [cte_pkg::ID_W-1:0]     o_out_src_port,
    output logic [cte_pkg::ID_W-1:0]     o_out_dst_module,
    output logic [cte_pkg::ID_W-1:0]     o_out_dst_port,
    output logic [cte_pkg::CNT_W-1:0]    o_entry_count,
    output logic [cte_pkg::CNT_W-1:0]    o_active_total,
    output logic                         o_last
);
    import cte_pkg::*;

    function automatic logic [SLOT_W-1:0] f_encode(input logic [TABLE_SLOTS-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (v[i]) begin
                idx = idx | SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    // table state
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [TABLE_SLOTS-1:0] n_valid;
    logic [EP_W-1:0]        r_ep [TABLE_SLOTS];
    logic [CNT_W-1:0]       r_active;
    logic [CNT_W-1:0]       n_active;
    logic                   ep_we;
    logic [SLOT_W-1:0]      ep_widx;

    // captured command
    logic [CMD_W-1:0]       r_cmd;
    logic [EP_W-1:0]        r_key;
    logic [CNT_W-1:0]       r_limit;
    logic [TABLE_SLOTS-1:0] r_mask;
    logic [TABLE_SLOTS-1:0] n_mask;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;

    // search vectors
    logic [TABLE_SLOTS-1:0] free_vec;
    logic [TABLE_SLOTS-1:0] free_low;
    logic [TABLE_SLOTS-1:0] match_vec;
    logic [TABLE_SLOTS-1:0] match_low;
    logic [TABLE_SLOTS-1:0] list_vec;
    logic [TABLE_SLOTS-1:0] list_low;
    logic [TABLE_SLOTS-1:0] list_rest;
    logic                   list_empty;
    logic                   list_last;
    logic [CNT_W-1:0]       count_inc;

    // result registers
    logic                   r_o_valid;
    logic                   n_o_valid;
    logic [STAT_W-1:0]      r_status,  n_status;
    logic                   r_has,     n_has;
    logic [EP_W-1:0]        r_out_ep,  n_out_ep;
    logic [CNT_W-1:0]       r_o_count, n_o_count;
    logic [CNT_W-1:0]       r_o_total, n_o_total;
    logic                   r_last,    n_last;

    always_comb begin
        free_vec = ~r_valid;
        free_low = free_vec & (~free_vec + TABLE_SLOTS'(1));
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            match_vec[i] = r_valid[i] && (r_ep[i] == r_key);
        end
        match_low  = match_vec & (~match_vec + TABLE_SLOTS'(1));
        list_vec   = r_valid & r_mask;
        list_low   = list_vec & (~list_vec + TABLE_SLOTS'(1));
        list_rest  = list_vec & ~list_low;
        count_inc  = r_count + CNT_W'(1);
        list_empty = (list_vec == '0) || (r_limit == '0);
        list_last  = list_empty || (list_rest == '0) || (count_inc == r_limit);
    end

    assign o_sts.is_list   = (r_cmd == CMD_LIST);
    assign o_sts.step_last = list_last;

    always_comb begin
        n_valid   = r_valid;
        n_active  = r_active;
        ep_we     = 1'b0;
        ep_widx   = f_encode(free_low);
        n_mask    = r_mask;
        n_count   = r_count;
        n_o_valid = 1'b0;
        n_status  = ST_OK;
        n_has     = 1'b0;
        n_out_ep  = '0;
        n_o_count = '0;
        n_o_total = r_active;
        n_last    = 1'b1;
        if (i_ctl.load) begin
            n_mask  = '1;
            n_count = '0;
        end
        if (i_ctl.exec) begin
            n_o_valid = 1'b1;
            unique case (r_cmd)
                CMD_ADD: begin
                    if (free_vec == '0) begin
                        n_status = ST_FULL;
                    end else begin
                        ep_we    = 1'b1;
                        n_valid  = r_valid | free_low;
                        n_active = r_active + CNT_W'(1);
                    end
                end
                CMD_REMOVE: begin
                    if (match_vec == '0) begin
                        n_status = ST_NOT_FOUND;
                    end else begin
                        n_valid  = r_valid & ~match_low;
                        n_active = r_active - CNT_W'(1);
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
            n_o_total = n_active;
        end
        if (i_ctl.step) begin
            n_o_valid = 1'b1;
            if (!list_empty) begin
                n_has     = 1'b1;
                n_out_ep  = r_ep[f_encode(list_low)];
                n_o_count = count_inc;
                n_last    = list_last;
                n_mask    = r_mask & ~list_low;
                n_count   = count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_active  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_active  <= n_active;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ep_we) begin
            r_ep[ep_widx] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_cmd;
            r_key   <= {i_src_module, i_src_port, i_dst_module, i_dst_port};
            r_limit <= (i_list_limit > CNT_W'(LIST_MAX)) ? CNT_W'(LIST_MAX) : i_list_limit;
        end
        r_mask    <= n_mask;
        r_count   <= n_count;
        r_status  <= n_status;
        r_has     <= n_has;
        r_out_ep  <= n_out_ep;
        r_o_count <= n_o_count;
        r_o_total <= n_o_total;
        r_last    <= n_last;
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_status;
    assign o_has_entry      = r_has;
    assign o_out_src_module = r_out_ep[EP_W-1 -: ID_W];
    assign o_out_src_port   = r_out_ep[EP_W-ID_W-1 -: ID_W];
    assign o_out_dst_module = r_out_ep[2*ID_W-1 -: ID_W];
    assign o_out_dst_port   = r_out_ep[ID_W-1:0];
    assign o_entry_count    = r_o_count;
    assign o_active_total   = r_o_total;
    assign o_last           = r_last;

    a_active_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_active) == 32'($countones(r_valid))))
        else $error("active count differs from number of valid slots");

    a_entry_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_entry) |-> (o_status == ST_OK))
        else $error("listed entry carries an error status");

    a_list_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=>
            (o_valid && o_has_entry && (o_entry_count == $past(o_entry_count) + CNT_W'(1))))
        else $error("list result sequence broken");

endmodule

>>> sv/connection_table_engine.sv
// Add, remove and unused commands: the start transfer moves the controller to S_EXEC,
// which registers the result; busy drops in the cycle it is shown, and not before.
// List: the first result is registered the same way, then one entry per cycle
// (a priority pick over the remaining valid slots) until the limit or the last slot.
// Results are shown for one cycle and cannot be stalled by the receiver.
// Synchronous active-low reset empties the table and clears the active count.
module connection_table_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [cte_pkg::CMD_W-1:0]    i_cmd,
    input  logic [cte_pkg::ID_W-1:0]     i_src_module,
    input  logic [cte_pkg::ID_W-1:0]     i_src_port,
    input  logic [cte_pkg::ID_W-1:0]     i_dst_module,
    input  logic [cte_pkg::ID_W-1:0]     i_dst_port,
    input  logic [cte_pkg::CNT_W-1:0]    i_list_limit,
    output logic                         o_valid,
    output logic [cte_pkg::STAT_W-1:0]   o_status,
    output logic                         o_has_entry,
    output logic [cte_pkg::ID_W-1:0]     o_out_src_module,
    output logic [cte_pkg::ID_W-1:0]     o_out_src_port,
    output logic [cte_pkg::ID_W-1:0]     o_out_dst_module,
    output logic [cte_pkg::ID_W-1:0]     o_out_dst_port,
    output logic [cte_pkg::CNT_W-1:0]    o_entry_count,
    output logic [cte_pkg::CNT_W-1:0]    o_active_total,
    output logic                         o_last
);
    import cte_pkg::*;

    t_ctl ctl;
    t_sts sts;

    cte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    cte_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .i_cmd            (i_cmd),
        .i_src_module     (i_src_module),
        .i_src_port       (i_src_port),
        .i_dst_module     (i_dst_module),
        .i_dst_port       (i_dst_port),
        .i_list_limit     (i_list_limit),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_has_entry      (o_has_entry),
        .o_out_src_module (o_out_src_module),
        .o_out_src_port   (o_out_src_port),
        .o_out_dst_module (o_out_dst_module),
        .o_out_dst_port   (o_out_dst_port),
        .o_entry_count    (o_entry_count),
        .o_active_total   (o_active_total),
        .o_last           (o_last)
    );

endmodule

>>> tb/sv/connection_table_engine_tb.sv
module connection_table_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cte_pkg::*;

    // command code the block treats as a no-op
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [EP_W-1:0]  ep;
        logic [CNT_W-1:0] limit;
    } t_table_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              has_entry;
        logic [EP_W-1:0]   ep;
        logic [CNT_W-1:0]  entry_count;
        logic [CNT_W-1:0]  active_total;
        logic              last;
    } t_table_reply;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    i_cmd;
    logic [ID_W-1:0]     i_src_module;
    logic [ID_W-1:0]     i_src_port;
    logic [ID_W-1:0]     i_dst_module;
    logic [ID_W-1:0]     i_dst_port;
    logic [CNT_W-1:0]    i_list_limit;
    logic                o_valid;
    logic [STAT_W-1:0]   o_status;
    logic                o_has_entry;
    logic [ID_W-1:0]     o_out_src_module;
    logic [ID_W-1:0]     o_out_src_port;
    logic [ID_W-1:0]     o_out_dst_module;
    logic [ID_W-1:0]     o_out_dst_port;
    logic [CNT_W-1:0]    o_entry_count;
    logic [CNT_W-1:0]    o_active_total;
    logic                o_last;

    connection_table_engine uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_src_module     (i_src_module),
        .i_src_port       (i_src_port),
        .i_dst_module     (i_dst_module),
        .i_dst_port       (i_dst_port),
        .i_list_limit     (i_list_limit),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_has_entry      (o_has_entry),
        .o_out_src_module (o_out_src_module),
        .o_out_src_port   (o_out_src_port),
        .o_out_dst_module (o_out_dst_module),
        .o_out_dst_port   (o_out_dst_port),
        .o_entry_count    (o_entry_count),
        .o_active_total   (o_active_total),
        .o_last           (o_last)
    );

    // predicted table contents
    logic                slot_live [TABLE_SLOTS];
    logic [EP_W-1:0]     slot_pair [TABLE_SLOTS];
    int                  live_count;

    t_table_cmd          cmd_backlog [$];
    t_table_reply        expected_replies [$];
    logic [EP_W-1:0]     known_pairs [$];

    logic                took;
    int                  gap_pct;
    int                  errors;
    int                  accepted;
    int                  checked;
    int                  listed;
    int                  fulls;
    int                  misses;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic flag(string what);
        errors++;
        if (errors <= 40)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic compare(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    function automatic void apply_command(t_table_cmd c);
        t_table_reply r;
        t_table_reply held;
        bit           have_held;
        bit           done;
        int           lim;
        int           n;
        int           i;
        r = '0;
        r.last = 1'b1;
        done = 1'b0;
        have_held = 1'b0;
        held = '0;
        n = 0;
        case (c.cmd)
            CMD_ADD: begin
                r.status = ST_FULL;
                for (i = 0; i < TABLE_SLOTS; i++) begin
                    if (!done && !slot_live[i]) begin
                        slot_live[i] = 1'b1;
                        slot_pair[i] = c.ep;
                        live_count++;
                        r.status = ST_OK;
                        done = 1'b1;
                    end
                end
                r.active_total = live_count[CNT_W-1:0];
                expected_replies.push_back(r);
            end
            CMD_REMOVE: begin
                r.status = ST_NOT_FOUND;
                for (i = 0; i < TABLE_SLOTS; i++) begin
                    if (!done && slot_live[i] && slot_pair[i] == c.ep) begin
                        slot_live[i] = 1'b0;
                        if (live_count > 0)
                            live_count--;
                        r.status = ST_OK;
                        done = 1'b1;
                    end
                end
                r.active_total = live_count[CNT_W-1:0];
                expected_replies.push_back(r);
            end
            CMD_LIST: begin
                lim = (int'(c.limit) < LIST_MAX) ? int'(c.limit) : LIST_MAX;
                for (i = 0; i < TABLE_SLOTS; i++) begin
                    if (slot_live[i] && n < lim) begin
                        // push the previous entry; only the final one carries last
                        if (have_held)
                            expected_replies.push_back(held);
                        n++;
                        held = '0;
                        held.status = ST_OK;
                        held.has_entry = 1'b1;
                        held.ep = slot_pair[i];
                        held.entry_count = n[CNT_W-1:0];
                        held.active_total = live_count[CNT_W-1:0];
                        have_held = 1'b1;
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    expected_replies.push_back(held);
                end else begin
                    r.active_total = live_count[CNT_W-1:0];
                    expected_replies.push_back(r);
                end
            end
            default: begin
                r.active_total = live_count[CNT_W-1:0];
                expected_replies.push_back(r);
            end
        endcase
    endfunction

    function automatic void queue_cmd(logic [CMD_W-1:0] cmd, logic [EP_W-1:0] ep,
                                      logic [CNT_W-1:0] limit);
        t_table_cmd c;
        c.cmd = cmd;
        c.ep = ep;
        c.limit = limit;
        cmd_backlog.push_back(c);
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(4, 0))
            0: pick_id = '0;
            1: pick_id = '1;
            2: pick_id = 8'h80;
            default: pick_id = ID_W'($urandom);
        endcase
    endfunction

    // mostly well-formed traffic: removes target entries that were added
    function automatic t_table_cmd random_command(int add_pct);
        t_table_cmd c;
        int         roll;
        int         k;
        c.ep = $urandom;
        c.limit = ($urandom_range(3, 0) == 0) ? CNT_W'($urandom_range(31, 17))
                                              : CNT_W'($urandom_range(16, 0));
        roll = $urandom_range(99, 0);
        if (roll < 4) begin
            c.cmd = CMD_UNUSED;
        end else if (roll < 18) begin
            c.cmd = CMD_LIST;
        end else if (roll < 18 + add_pct * 82 / 100) begin
            c.cmd = CMD_ADD;
            if (known_pairs.size() > 0 && $urandom_range(4, 0) == 0)
                c.ep = known_pairs[$urandom_range(known_pairs.size() - 1, 0)];
            else if ($urandom_range(1, 0) == 0)
                c.ep = {pick_id(), pick_id(), pick_id(), pick_id()};
            if (known_pairs.size() < 24)
                known_pairs.push_back(c.ep);
        end else begin
            c.cmd = CMD_REMOVE;
            if (known_pairs.size() > 0 && $urandom_range(3, 0) != 0) begin
                k = $urandom_range(known_pairs.size() - 1, 0);
                c.ep = known_pairs[k];
                if ($urandom_range(9, 0) == 0)
                    c.ep[$urandom_range(EP_W - 1, 0)] ^= 1'b1;
                else
                    known_pairs.delete(k);
            end
        end
        return c;
    endfunction

    task automatic drain();
        while (cmd_backlog.size() > 0 || start || expected_replies.size() > 0)
            @(posedge i_clk);
    endtask

    // driver: hold each command until the transfer completes
    always @(negedge i_clk) begin
        if (took && cmd_backlog.size() > 0)
            void'(cmd_backlog.pop_front());
        if (!start || took) begin
            if (i_rst_n && cmd_backlog.size() > 0 && $urandom_range(99, 0) >= gap_pct) begin
                start        <= 1'b1;
                i_cmd        <= cmd_backlog[0].cmd;
                i_src_module <= cmd_backlog[0].ep[31:24];
                i_src_port   <= cmd_backlog[0].ep[23:16];
                i_dst_module <= cmd_backlog[0].ep[15:8];
                i_dst_port   <= cmd_backlog[0].ep[7:0];
                i_list_limit <= cmd_backlog[0].limit;
            end else begin
                start        <= 1'b0;
                i_cmd        <= CMD_W'($urandom);
                i_src_module <= ID_W'($urandom);
                i_src_port   <= ID_W'($urandom);
                i_dst_module <= ID_W'($urandom);
                i_dst_port   <= ID_W'($urandom);
                i_list_limit <= CNT_W'($urandom);
            end
        end
    end

    // monitor: check results, then predict from the command taken at this edge
    always @(posedge i_clk) begin : monitor
        t_table_reply want;
        t_table_cmd   seen;
        if (!i_rst_n) begin
            took <= 1'b0;
            slot_live = '{default: 1'b0};
            slot_pair = '{default: '0};
            live_count = 0;
            expected_replies.delete();
        end else begin
            if (o_valid) begin
                if (expected_replies.size() == 0) begin
                    flag("result strobe with nothing expected");
                end else begin
                    want = expected_replies.pop_front();
                    checked++;
                    if (want.has_entry)
                        listed++;
                    if (want.status == ST_FULL)
                        fulls++;
                    if (want.status == ST_NOT_FOUND)
                        misses++;
                    compare("status", 32'(o_status), 32'(want.status));
                    compare("has_entry", 32'(o_has_entry), 32'(want.has_entry));
                    compare("src_module", 32'(o_out_src_module), 32'(want.ep[31:24]));
                    compare("src_port", 32'(o_out_src_port), 32'(want.ep[23:16]));
                    compare("dst_module", 32'(o_out_dst_module), 32'(want.ep[15:8]));
                    compare("dst_port", 32'(o_out_dst_port), 32'(want.ep[7:0]));
                    compare("entry_count", 32'(o_entry_count), 32'(want.entry_count));
                    compare("active_total", 32'(o_active_total), 32'(want.active_total));
                    compare("last", 32'(o_last), 32'(want.last));
                end
            end
            took <= start && !busy;
            if (start && !busy) begin
                seen = {i_cmd, i_src_module, i_src_port, i_dst_module, i_dst_port,
                        i_list_limit};
                apply_command(seen);
                accepted++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_replies.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int phase_gap [4];
        int burst_add [3];
        int p;
        int b;
        int j;
        phase_gap = '{0, 66, 30, 0};
        burst_add = '{85, 50, 20};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        i_src_module = '0;
        i_src_port = '0;
        i_dst_module = '0;
        i_dst_port = '0;
        i_list_limit = '0;
        gap_pct = 0;
        errors = 0;
        accepted = 0;
        checked = 0;
        listed = 0;
        fulls = 0;
        misses = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table: list gives the empty result, remove misses, unused command is a no-op
        queue_cmd(CMD_LIST, 32'h0000_0000, 5'd16);
        queue_cmd(CMD_REMOVE, 32'h0000_0000, 5'd0);
        queue_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 5'd31);
        queue_cmd(CMD_ADD, 32'h0000_0000, 5'd0);
        queue_cmd(CMD_ADD, 32'hFFFF_FFFF, 5'd31);
        queue_cmd(CMD_ADD, 32'hFFFF_FFFF, 5'd0);
        queue_cmd(CMD_ADD, 32'h1234_5678, 5'd0);
        queue_cmd(CMD_LIST, 32'hFFFF_FFFF, 5'd0);
        queue_cmd(CMD_LIST, 32'h0000_0000, 5'd31);
        // duplicate: lowest matching slot goes
        queue_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 5'd0);
        // one field off: no match
        queue_cmd(CMD_REMOVE, 32'h1234_5679, 5'd0);
        queue_cmd(CMD_ADD, 32'hA5C3_0F81, 5'd0);
        for (j = 0; j < 12; j++)
            queue_cmd(CMD_ADD, {8'(j), 8'(j * 17), 8'(255 - j), 8'(j << 4)}, 5'd0);
        queue_cmd(CMD_ADD, 32'h5A5A_5A5A, 5'd0);
        queue_cmd(CMD_LIST, 32'h0000_0000, 5'd5);
        queue_cmd(CMD_LIST, 32'h0000_0000, 5'd16);
        known_pairs = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5C3_0F81};
        drain();

        for (p = 0; p < 4; p++) begin
            gap_pct = phase_gap[p];
            for (b = 0; b < 3; b++)
                for (j = 0; j < 25; j++)
                    cmd_backlog.push_back(random_command(burst_add[b]));
            drain();
        end

        repeat (8) @(posedge i_clk);
        while (expected_replies.size() > 0)
            flag($sformatf("expected result never arrived, status %0d",
                           expected_replies.pop_front().status));
        $display("%0d commands over four pacing phases, %0d results checked",
                 accepted, checked);
        $display("%0d listed entries, %0d table-full and %0d not-found replies, %0d errors",
                 listed, fulls, misses, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
